@@ hdl/cos_pkg.sv @@
// shared types and constants for the cosine similarity stream
// no dependencies
`default_nettype none
package cos_pkg;

    localparam int ELEMENT_BITS = 16;
    localparam int DOT_BITS     = 2 * ELEMENT_BITS + 10;
    localparam int ENERGY_BITS  = 2 * ELEMENT_BITS + 9;
    localparam int MAG_BITS     = DOT_BITS;
    localparam int PROD_BITS    = 2 * ENERGY_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int SIM_BITS     = 16;
    localparam int ROOT_BITS    = SIM_BITS + 1;
    localparam int SCALE_SHIFT  = 2 * (SIM_BITS - 1);
    localparam int ROOT_W       = PROD_BITS + 2 * ROOT_BITS + 2;
    localparam int MUL_STEPS    = MAG_BITS;
    localparam int CNT_BITS     = $clog2(MUL_STEPS);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [ROOT_BITS-1:0] ROOT_MAX = ROOT_BITS'(1) << (SIM_BITS - 1);
    localparam logic [ROOT_BITS-1:0] SIM_MAX  = ROOT_MAX - ROOT_BITS'(1);

    typedef struct packed {
        logic signed [DOT_BITS-1:0] dot;
        logic [ENERGY_BITS-1:0]     q_energy;
        logic [ENERGY_BITS-1:0]     d_energy;
        logic                       batch;
    } cos_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_DONE
    } cos_state_t;

endpackage
`default_nettype wire

@@ hdl/cos_if.sv @@
// element and result channel interfaces
// depends on cos_pkg
`default_nettype none
interface cos_elem_if import cos_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] query_element;
    logic signed [ELEMENT_BITS-1:0] database_element;
    logic                           last_element;
    logic                           last_vector;

    modport source (output valid, query_element, database_element, last_element,
                    last_vector, input ready);
    modport sink (input valid, query_element, database_element, last_element,
                  last_vector, output ready);
endinterface

interface cos_result_if import cos_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SIM_BITS-1:0] similarity;
    logic                       zero_norm;
    logic                       batch_done;

    modport source (output valid, similarity, zero_norm, batch_done, input ready);
    modport sink (input valid, similarity, zero_norm, batch_done, output ready);
endinterface
`default_nettype wire

@@ hdl/cos_front.sv @@
// front end: accumulates dot product and energies, pushes a job per vector pair
// depends on cos_pkg and cos_if
`default_nettype none
module cos_front import cos_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cos_elem_if.sink    elem,
    input  wire logic   job_full,
    output logic        job_push,
    output cos_job_t    job
);

    logic signed [DOT_BITS-1:0] dot_reg, dot_next;
    logic [ENERGY_BITS-1:0]     qe_reg, qe_next, de_reg, de_next;
    logic signed [2*ELEMENT_BITS-1:0] prod_qd, prod_qq, prod_dd;
    logic signed [DOT_BITS:0]   dot_sum;
    logic [ENERGY_BITS:0]       qe_sum, de_sum;
    logic signed [DOT_BITS-1:0] dot_sat;
    logic [ENERGY_BITS-1:0]     qe_sat, de_sat;
    logic                       accept;

    localparam logic signed [DOT_BITS:0] DMAX = (DOT_BITS+1)'((65'(1) << (DOT_BITS-1)) - 65'(1));
    localparam logic signed [DOT_BITS:0] DMIN = -DMAX - (DOT_BITS+1)'(1);

    assign elem.ready = !job_full;
    assign accept     = elem.valid && elem.ready;

    always_comb
    begin
        prod_qd = elem.query_element * elem.database_element;
        prod_qq = elem.query_element * elem.query_element;
        prod_dd = elem.database_element * elem.database_element;
        dot_sum = (DOT_BITS+1)'(dot_reg) + (DOT_BITS+1)'(prod_qd);
        qe_sum  = {1'b0, qe_reg} + (ENERGY_BITS+1)'($unsigned(prod_qq));
        de_sum  = {1'b0, de_reg} + (ENERGY_BITS+1)'($unsigned(prod_dd));
        if (dot_sum > DMAX)
            dot_sat = DOT_BITS'(DMAX);
        else if (dot_sum < DMIN)
            dot_sat = DOT_BITS'(DMIN);
        else
            dot_sat = DOT_BITS'(dot_sum);
        qe_sat = qe_sum[ENERGY_BITS] ? '1 : qe_sum[ENERGY_BITS-1:0];
        de_sat = de_sum[ENERGY_BITS] ? '1 : de_sum[ENERGY_BITS-1:0];
    end

    always_comb
    begin
        dot_next = dot_reg;
        qe_next  = qe_reg;
        de_next  = de_reg;
        if (accept)
        begin
            if (elem.last_element)
            begin
                dot_next = '0;
                qe_next  = '0;
                de_next  = '0;
            end
            else
            begin
                dot_next = dot_sat;
                qe_next  = qe_sat;
                de_next  = de_sat;
            end
        end
    end

    assign job_push       = accept && elem.last_element;
    assign job.dot        = dot_sat;
    assign job.q_energy   = qe_sat;
    assign job.d_energy   = de_sat;
    assign job.batch      = elem.last_vector;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            qe_reg  <= '0;
            de_reg  <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            qe_reg  <= qe_next;
            de_reg  <= de_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |=> (dot_reg == '0 && qe_reg == '0 && de_reg == '0))
        else $error("sums not cleared after last beat");

endmodule
`default_nettype wire

@@ hdl/cos_queue.sv @@
// short job queue between front and back end
// depends on cos_pkg
`default_nettype none
module cos_queue import cos_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cos_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          avail,
    output cos_job_t      head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cos_job_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_BITS:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign full    = count_reg == (PTR_BITS+1)'(QUEUE_DEPTH);
    assign avail   = count_reg != '0;
    assign head    = entry_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_next    = do_push ? PTR_BITS'(wr_reg + 1'b1) : wr_reg;
        rd_next    = do_pop ? PTR_BITS'(rd_reg + 1'b1) : rd_reg;
        count_next = count_reg + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule
`default_nettype wire

@@ hdl/cos_back.sv @@
// back end: serial multiplies, bitwise square-root search, result register
// depends on cos_pkg and cos_if
`default_nettype none
module cos_back import cos_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_avail,
    input  wire cos_job_t job,
    output logic          job_pop,
    cos_result_if.source  result
);

    cos_state_t              state_reg, state_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    neg_reg, neg_next, zero_reg, zero_next, batch_reg, batch_next;
    logic [PROD_BITS-1:0]    pcand_reg, pcand_next, pacc_reg, pacc_next;
    logic [ENERGY_BITS-1:0]  pmul_reg, pmul_next;
    logic [SQ_BITS-1:0]      acand_reg, acand_next, aacc_reg, aacc_next;
    logic [MAG_BITS-1:0]     amul_reg, amul_next;
    logic [ROOT_W-1:0]       t_reg, t_next, uk_reg, uk_next, pk_reg, pk_next, b_reg, b_next;
    logic [ROOT_BITS-1:0]    r_reg, r_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SIM_BITS-1:0] sim_reg, sim_next;
    logic                    ozero_reg, ozero_next, obatch_reg, obatch_next;
    logic [MAG_BITS-1:0]     mag_in;
    logic [ROOT_W-1:0]       cand;
    logic                    fits;
    logic                    out_free;
    logic [ROOT_BITS-1:0]    m_cap, m_neg;

    assign out_free = !out_valid_reg || result.ready;
    assign mag_in   = job.dot[DOT_BITS-1] ? MAG_BITS'(-job.dot) : MAG_BITS'(job.dot);
    assign cand     = t_reg + uk_reg + pk_reg;
    assign fits     = cand <= b_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_avail)
                    state_next = (job.q_energy == '0 || job.d_energy == '0) ? ST_DONE : ST_MUL;
            ST_MUL:
                if (cnt_reg == '0)
                    state_next = ST_ROOT;
            ST_ROOT:
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop    = state_reg == ST_IDLE && job_avail;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        batch_next = batch_reg;
        pcand_next = pcand_reg;
        pacc_next  = pacc_reg;
        pmul_next  = pmul_reg;
        acand_next = acand_reg;
        aacc_next  = aacc_reg;
        amul_next  = amul_reg;
        t_next     = t_reg;
        uk_next    = uk_reg;
        pk_next    = pk_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                neg_next   = job.dot[DOT_BITS-1];
                zero_next  = job.q_energy == '0 || job.d_energy == '0;
                batch_next = job.batch;
                pcand_next = PROD_BITS'(job.q_energy);
                pmul_next  = job.d_energy;
                pacc_next  = '0;
                acand_next = SQ_BITS'(mag_in);
                amul_next  = mag_in;
                aacc_next  = '0;
                r_next     = '0;
                cnt_next   = CNT_BITS'(MUL_STEPS - 1);
            end
            ST_MUL:
            begin
                pacc_next  = pmul_reg[0] ? pacc_reg + pcand_reg : pacc_reg;
                aacc_next  = amul_reg[0] ? aacc_reg + acand_reg : aacc_reg;
                pcand_next = pcand_reg << 1;
                acand_next = acand_reg << 1;
                pmul_next  = pmul_reg >> 1;
                amul_next  = amul_reg >> 1;
                cnt_next   = CNT_BITS'(cnt_reg - 1'b1);
                if (cnt_reg == '0)
                begin
                    t_next   = '0;
                    uk_next  = '0;
                    pk_next  = ROOT_W'(pacc_next) << (2 * (ROOT_BITS - 1));
                    b_next   = ROOT_W'(aacc_next) << SCALE_SHIFT;
                    cnt_next = CNT_BITS'(ROOT_BITS - 1);
                end
            end
            ST_ROOT:
            begin
                t_next   = fits ? cand : t_reg;
                uk_next  = (uk_reg >> 1) + (fits ? pk_reg : '0);
                pk_next  = pk_reg >> 2;
                r_next   = {r_reg[ROOT_BITS-2:0], fits};
                cnt_next = CNT_BITS'(cnt_reg - 1'b1);
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_cap          = (r_reg > ROOT_MAX) ? ROOT_MAX : r_reg;
        m_neg          = ROOT_BITS'(-m_cap);
        out_valid_next = out_valid_reg && !result.ready;
        sim_next       = sim_reg;
        ozero_next     = ozero_reg;
        obatch_next    = obatch_reg;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            ozero_next     = zero_reg;
            obatch_next    = batch_reg;
            if (zero_reg)
                sim_next = '0;
            else if (neg_reg)
                sim_next = SIM_BITS'(m_neg);
            else
                sim_next = (m_cap > SIM_MAX) ? SIM_BITS'(SIM_MAX) : SIM_BITS'(m_cap);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.similarity = sim_reg;
    assign result.zero_norm  = ozero_reg;
    assign result.batch_done = obatch_reg;

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        batch_reg  <= batch_next;
        pcand_reg  <= pcand_next;
        pacc_reg   <= pacc_next;
        pmul_reg   <= pmul_next;
        acand_reg  <= acand_next;
        aacc_reg   <= aacc_next;
        amul_reg   <= amul_next;
        t_reg      <= t_next;
        uk_reg     <= uk_next;
        pk_reg     <= pk_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        sim_reg    <= sim_next;
        ozero_reg  <= ozero_next;
        obatch_reg <= obatch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_norm) |-> result.similarity == '0)
        else $error("zero norm result not zero");

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROOT |-> cnt_reg < CNT_BITS'(ROOT_BITS))
        else $error("root step count out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> state_reg != ST_IDLE)
        else $error("job popped but back end stayed idle");

endmodule
`default_nettype wire

@@ hdl/cosine_similarity_stream.sv @@
// Streaming cosine similarity: one element pair per beat is accumulated while the
// job queue has room. For each result the back end runs one load step, 42 serial
// multiply steps, 17 root steps and one output step (a job with a zero energy goes
// straight from load to output); a two-entry job queue lets the next vectors stream
// in meanwhile, and the input stalls only when that queue is full.
// depends on cos_pkg, cos_if, cos_front, cos_queue and cos_back
`default_nettype none
module cosine_similarity_stream import cos_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cos_elem_if.sink     elem,
    cos_result_if.source result
);

    cos_job_t push_job, head_job;
    logic     job_push, job_full, job_avail, job_pop;

    cos_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .elem     (elem),
        .job_full (job_full),
        .job_push (job_push),
        .job      (push_job)
    );

    cos_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .avail    (job_avail),
        .head     (head_job)
    );

    cos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job       (head_job),
        .job_pop   (job_pop),
        .result    (result)
    );

endmodule
`default_nettype wire

@@ test/cos_tb_pkg.sv @@
// scoreboard for the cosine similarity stream testbench
// depends on cos_pkg
package cos_tb_pkg;
    import cos_pkg::*;

    typedef struct {
        logic signed [SIM_BITS-1:0] similarity;
        logic                       zero_norm;
        logic                       batch_done;
    } cos_result_t;

    class cos_scoreboard;
        logic signed [DOT_BITS-1:0] dot_acc;
        logic [ENERGY_BITS-1:0]     q_energy;
        logic [ENERGY_BITS-1:0]     d_energy;
        cos_result_t                pending[$];
        int                         mismatches;

        function new();
            dot_acc = '0;
            q_energy = '0;
            d_energy = '0;
            mismatches = 0;
        endfunction

        // largest r in 0..32768 with r*r*qe*de <= 2^30*a*a
        function automatic int unsigned magnitude(logic [DOT_BITS-1:0] a,
                                                  logic [ENERGY_BITS-1:0] qe,
                                                  logic [ENERGY_BITS-1:0] de);
            logic [255:0] prod;
            logic [255:0] bound;
            logic [255:0] trial;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            prod = 256'(qe) * 256'(de);
            bound = (256'(a) * 256'(a)) << 30;
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                trial = prod * 256'(mid) * 256'(mid);
                if (trial <= bound)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_beat(logic signed [ELEMENT_BITS-1:0] q,
                                logic signed [ELEMENT_BITS-1:0] d,
                                logic last, logic batch);
            longint      s;
            longint      dmax;
            longint      qq;
            longint      dd;
            longint      emax;
            logic        neg;
            longint      a;
            int unsigned m;
            cos_result_t r;
            dmax = (longint'(1) <<< (DOT_BITS - 1)) - 1;
            emax = (longint'(1) <<< ENERGY_BITS) - 1;
            s = longint'(dot_acc) + longint'(q) * longint'(d);
            dot_acc = DOT_BITS'(s > dmax ? dmax : (s < -dmax - 1 ? -dmax - 1 : s));
            qq = longint'(q_energy) + longint'(q) * longint'(q);
            dd = longint'(d_energy) + longint'(d) * longint'(d);
            q_energy = ENERGY_BITS'(qq > emax ? emax : qq);
            d_energy = ENERGY_BITS'(dd > emax ? emax : dd);
            if (!last)
                return;
            r.similarity = '0;
            r.zero_norm = 1'b0;
            r.batch_done = batch;
            if (q_energy == 0 || d_energy == 0)
                r.zero_norm = 1'b1;
            else
            begin
                neg = dot_acc < 0;
                a = neg ? -longint'(dot_acc) : longint'(dot_acc);
                m = magnitude(DOT_BITS'(a), q_energy, d_energy);
                if (neg)
                    r.similarity = SIM_BITS'(-int'(m));
                else
                    r.similarity = m > 32767 ? 16'sd32767 : SIM_BITS'(m);
            end
            pending.push_back(r);
            dot_acc = '0;
            q_energy = '0;
            d_energy = '0;
        endfunction

        function void check_result(logic signed [SIM_BITS-1:0] sim, logic zn, logic bd);
            cos_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sim %0d zero_norm %0b batch_done %0b",
                             sim, zn, bd);
                return;
            end
            e = pending.pop_front();
            if (sim !== e.similarity || zn !== e.zero_norm || bd !== e.batch_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected sim %0d zn %0b bd %0b, got sim %0d zn %0b bd %0b",
                             e.similarity, e.zero_norm, e.batch_done, sim, zn, bd);
            end
        endfunction
    endclass
endpackage

@@ test/cosine_similarity_stream_tb.sv @@
// top-level testbench for cosine_similarity_stream: directed and random vectors
// depends on cos_pkg, cos_if, cos_tb_pkg and the block
module cosine_similarity_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cos_pkg::*;
    import cos_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    int   quiet_cycles;

    cos_elem_if   elem();
    cos_result_if result();
    cos_scoreboard similarity_board;

    cosine_similarity_stream i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem),
        .result (result)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            similarity_board.check_result(result.similarity, result.zero_norm,
                                          result.batch_done);
        result.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // input acceptance and watchdog
    always @(posedge clk)
    begin
        if (rst_n && elem.valid && elem.ready)
            similarity_board.note_beat(elem.query_element, elem.database_element,
                                       elem.last_element, elem.last_vector);
        if (rst_n && !((elem.valid && elem.ready) || (result.valid && result.ready)))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_beat(logic signed [15:0] q, logic signed [15:0] d,
                             logic last, logic batch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            elem.valid <= 1'b0;
            @(posedge clk);
        end
        elem.valid <= 1'b1;
        elem.query_element <= q;
        elem.database_element <= d;
        elem.last_element <= last;
        elem.last_vector <= batch;
        @(posedge clk);
        while (!elem.ready)
            @(posedge clk);
    endtask

    task automatic go_idle();
        elem.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'(signed'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(int len, int kind);
        logic signed [15:0] q;
        logic signed [15:0] d;
        int                 mode;
        for (int i = 0; i < len; i++)
        begin
            mode = $urandom_range(7) == 0 ? $urandom_range(3) : 4;
            q = rand_elem(mode);
            d = rand_elem(mode);
            if (kind == 1)
                d = q;
            else if (kind == 2)
                d = -q;
            else if (kind == 3)
                d = 16'($urandom_range(1)) ? 16'sh0 : d;
            send_beat(q, d, i == len - 1,
                      i == len - 1 ? 1'($urandom) : 1'($urandom_range(3) == 0));
        end
    endtask

    task automatic drain();
        elem.valid <= 1'b0;
        while (similarity_board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int len;
        similarity_board = new();
        elem.valid = 1'b0;
        elem.query_element = '0;
        elem.database_element = '0;
        elem.last_element = 1'b0;
        elem.last_vector = 1'b0;
        result.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero norms, exact plus and minus one
        send_beat(16'sh7fff, 16'sh7fff, 1, 0);
        send_beat(16'sh8000, 16'sh8000, 1, 1);
        send_beat(16'sh8000, 16'sh7fff, 1, 0);
        send_beat(16'sh7fff, 16'sh8000, 1, 1);
        send_beat(16'sh0000, 16'sh1234, 1, 0);
        send_beat(16'sh1234, 16'sh0000, 1, 1);
        send_beat(16'sh0000, 16'sh0000, 1, 0);
        send_beat(16'sh0001, 16'shffff, 1, 1);
        send_beat(16'sh3000, 16'sh0000, 0, 1);
        send_beat(16'sh0000, 16'sh3000, 1, 0);
        send_beat(16'sh5555, 16'shaaaa, 0, 0);
        send_beat(16'shaaaa, 16'sh5555, 0, 1);
        send_beat(16'sh1000, 16'sh1001, 1, 1);
        send_beat(16'sh0003, 16'sh0004, 0, 0);
        send_beat(16'sh0004, 16'sh0003, 1, 0);
        drain();

        // longer vectors, identical and opposite
        send_vector(150, 1);
        send_vector(130, 2);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase == 1 || phase == 3 ? (phase == 1 ? 76 : 35) : 0;
            recv_stall_pct = phase == 2 ? 76 : (phase == 3 ? 35 : 0);
            if (phase == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int v = 0; v < 20; v++)
            begin
                len = $urandom_range(9) == 0 ? $urandom_range(80, 20) : $urandom_range(1, 6);
                send_vector(len, $urandom_range(4));
                if ($urandom_range(9) == 0)
                    go_idle();
            end
            drain();
        end

        if (similarity_board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
